// ===== rtl/core/h4rx_pkg.sv =====
// ----------------------------------------------------------------------------
// H4 receive deframer package
// Shared types and codes for the HCI H4 receive deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package h4rx_pkg;

  // H4 packet type bytes
  localparam logic [7:0] H4_TYPE_EVT = 8'h04;
  localparam logic [7:0] H4_TYPE_ACL = 8'h02;
  localparam logic [7:0] H4_TYPE_ISO = 8'h05;

  // Event codes
  localparam logic [7:0] EVT_LE_META       = 8'h3E;
  localparam logic [7:0] LE_SUB_ADV_REPORT = 8'h02;

  // Packet kind codes
  localparam logic [1:0] KIND_NONE = 2'd0;
  localparam logic [1:0] KIND_EVT  = 2'd1;
  localparam logic [1:0] KIND_ACL  = 2'd2;
  localparam logic [1:0] KIND_ISO  = 2'd3;

  // Byte role codes
  localparam logic [2:0] ROLE_TYPE    = 3'd0;
  localparam logic [2:0] ROLE_HEADER  = 3'd1;
  localparam logic [2:0] ROLE_PAYLOAD = 3'd2;
  localparam logic [2:0] ROLE_DISCARD = 3'd3;
  localparam logic [2:0] ROLE_UNKNOWN = 3'd4;

  // Header lengths
  localparam logic [2:0] HDR_LEN_EVT  = 3'd2;
  localparam logic [2:0] HDR_LEN_META = 3'd3;
  localparam logic [2:0] HDR_LEN_ACL  = 3'd4;

  // Configuration register indexes
  localparam logic [0:0] CFG_MAX_PAYLOAD = 1'b0;
  localparam logic [0:0] CFG_ISO_ENABLE  = 1'b1;

  localparam logic [15:0] MAX_PAYLOAD_RESET = 16'd1024;

  typedef struct packed {
    logic [15:0] max_payload;
    logic        iso_enable;
  } h4rx_cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] packet_kind;
    logic [2:0] byte_role;
    logic       packet_end;
    logic       too_long;
    logic       discardable;
  } h4rx_result_t;

endpackage

`default_nettype wire

// ===== rtl/core/h4rx_cfg.sv =====
// ----------------------------------------------------------------------------
// H4 receive deframer configuration registers
// Holds max_payload and iso_enable, written through a plain write port.
// ----------------------------------------------------------------------------
`default_nettype none

module h4rx_cfg (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic [0:0]        cfg_index,
  input  wire logic [15:0]       cfg_data,
  output h4rx_pkg::h4rx_cfg_t    cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.max_payload <= h4rx_pkg::MAX_PAYLOAD_RESET;
      cfg.iso_enable  <= 1'b1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        h4rx_pkg::CFG_MAX_PAYLOAD: cfg.max_payload <= cfg_data;
        h4rx_pkg::CFG_ISO_ENABLE:  cfg.iso_enable  <= cfg_data[0];
        default:                   cfg.iso_enable  <= cfg.iso_enable;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/h4rx_parser.sv =====
// ----------------------------------------------------------------------------
// H4 receive deframer parser
// Packet state and the per-byte classification, one byte per step.
// ----------------------------------------------------------------------------
`default_nettype none

module h4rx_parser (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  step,
  input  wire logic [7:0]            rx_byte,
  input  wire h4rx_pkg::h4rx_cfg_t   cfg,
  output h4rx_pkg::h4rx_result_t     res
);

  logic [1:0]  current_kind, current_kind_next;
  logic [7:0]  header_store [4];
  logic [7:0]  header_store_next [4];
  logic [2:0]  header_length, header_length_next;
  logic [15:0] bytes_left, bytes_left_next;
  logic        header_complete, header_complete_next;
  logic [15:0] discard_left, discard_left_next;
  logic        discard_mark, discard_mark_next;

  always_comb begin
    logic [1:0]  pos;
    logic [2:0]  hdr_diff;
    logic [15:0] len;
    logic        ext;

    current_kind_next    = current_kind;
    header_store_next    = header_store;
    header_length_next   = header_length;
    bytes_left_next      = bytes_left;
    header_complete_next = header_complete;
    discard_left_next    = discard_left;
    discard_mark_next    = discard_mark;
    hdr_diff             = header_length - bytes_left[2:0];
    pos                  = hdr_diff[1:0];
    len                  = '0;
    ext                  = 1'b0;

    res.out_byte    = rx_byte;
    res.packet_kind = h4rx_pkg::KIND_NONE;
    res.byte_role   = h4rx_pkg::ROLE_TYPE;
    res.packet_end  = 1'b0;
    res.too_long    = 1'b0;
    res.discardable = 1'b0;

    if (discard_left != 16'd0) begin
      // Drop payload of an oversized packet
      discard_left_next = discard_left - 16'd1;
      res.byte_role     = h4rx_pkg::ROLE_DISCARD;
    end else if (current_kind == h4rx_pkg::KIND_NONE) begin
      if (rx_byte == h4rx_pkg::H4_TYPE_EVT) begin
        current_kind_next  = h4rx_pkg::KIND_EVT;
        header_length_next = h4rx_pkg::HDR_LEN_EVT;
      end else if (rx_byte == h4rx_pkg::H4_TYPE_ACL) begin
        current_kind_next  = h4rx_pkg::KIND_ACL;
        header_length_next = h4rx_pkg::HDR_LEN_ACL;
      end else if (rx_byte == h4rx_pkg::H4_TYPE_ISO && cfg.iso_enable) begin
        current_kind_next  = h4rx_pkg::KIND_ISO;
        header_length_next = h4rx_pkg::HDR_LEN_ACL;
      end
      if (current_kind_next != h4rx_pkg::KIND_NONE) begin
        bytes_left_next      = {13'd0, header_length_next};
        header_complete_next = 1'b0;
        discard_mark_next    = 1'b0;
        res.packet_kind      = current_kind_next;
      end else begin
        res.byte_role = h4rx_pkg::ROLE_UNKNOWN;
      end
    end else if (!header_complete) begin
      header_store_next[pos] = rx_byte;
      bytes_left_next        = bytes_left - 16'd1;
      res.packet_kind        = current_kind;
      res.byte_role          = h4rx_pkg::ROLE_HEADER;
      // Extend the header by the subevent byte for an LE meta event
      if (current_kind == h4rx_pkg::KIND_EVT && header_length == h4rx_pkg::HDR_LEN_EVT &&
          bytes_left_next < 16'd2 && header_store_next[0] == h4rx_pkg::EVT_LE_META) begin
        bytes_left_next    = bytes_left_next + 16'd1;
        header_length_next = h4rx_pkg::HDR_LEN_META;
      end
      if (bytes_left_next == 16'd0) begin
        if (current_kind == h4rx_pkg::KIND_EVT) begin
          ext = (header_length_next == h4rx_pkg::HDR_LEN_META);
          len = (header_store_next[1] > {7'd0, ext}) ?
                {8'd0, header_store_next[1] - {7'd0, ext}} : 16'd0;
          if (header_store_next[0] == h4rx_pkg::EVT_LE_META && ext &&
              header_store_next[2] == h4rx_pkg::LE_SUB_ADV_REPORT) begin
            discard_mark_next = 1'b1;
          end
        end else begin
          len = {header_store_next[3], header_store_next[2]};
          if (current_kind == h4rx_pkg::KIND_ISO) begin
            len[15:14] = 2'b00;
          end
        end
        res.discardable = discard_mark_next;
        priority if (len > cfg.max_payload) begin
          res.too_long         = 1'b1;
          discard_left_next    = len;
          current_kind_next    = h4rx_pkg::KIND_NONE;
          header_length_next   = '0;
          bytes_left_next      = '0;
          header_complete_next = 1'b0;
          discard_mark_next    = 1'b0;
        end else if (len == 16'd0) begin
          res.packet_end       = 1'b1;
          current_kind_next    = h4rx_pkg::KIND_NONE;
          header_length_next   = '0;
          bytes_left_next      = '0;
          header_complete_next = 1'b0;
          discard_mark_next    = 1'b0;
        end else begin
          header_complete_next = 1'b1;
          bytes_left_next      = len;
        end
      end else begin
        res.discardable = discard_mark;
      end
    end else begin
      res.packet_kind = current_kind;
      res.byte_role   = h4rx_pkg::ROLE_PAYLOAD;
      res.discardable = discard_mark;
      bytes_left_next = bytes_left - 16'd1;
      if (bytes_left_next == 16'd0) begin
        res.packet_end       = 1'b1;
        current_kind_next    = h4rx_pkg::KIND_NONE;
        header_length_next   = '0;
        header_complete_next = 1'b0;
        discard_mark_next    = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_kind    <= h4rx_pkg::KIND_NONE;
      header_length   <= '0;
      bytes_left      <= '0;
      header_complete <= 1'b0;
      discard_left    <= '0;
      discard_mark    <= 1'b0;
    end else if (step) begin
      current_kind    <= current_kind_next;
      header_length   <= header_length_next;
      bytes_left      <= bytes_left_next;
      header_complete <= header_complete_next;
      discard_left    <= discard_left_next;
      discard_mark    <= discard_mark_next;
    end
  end

  // Header bytes carry no reset
  always_ff @(posedge clk) begin
    if (step) begin
      header_store <= header_store_next;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/hci_h4_rx_deframer.sv =====
// A byte accepted on the input side passes the input register, the parser logic
// and the result register before it is offered on the master side.
// Throughput: one byte per cycle while the master side does not stall.
// The input side keeps accepting while a result waits, up to one buffered byte.
// Reset (rst, synchronous, active high) empties both registers, returns the
// parser to waiting for a type byte and loads max_payload 1024, iso_enable 1.
// ----------------------------------------------------------------------------
// HCI H4 receive deframer
// Splits a received byte stream into H4 event, ACL and ISO packets.
// ----------------------------------------------------------------------------
`default_nettype none

module hci_h4_rx_deframer (
  input  wire logic        clk,
  input  wire logic        rst,
  // Input stream
  input  wire logic        s_axis_tvalid,
  output      logic        s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  // Output stream
  output      logic        m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output      logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output      logic [6:0]  m_axis_tuser,   // [1:0] packet_kind, [4:2] byte_role,
                                           // [5] too_long, [6] discardable
  output      logic        m_axis_tlast,   // packet_end
  // Configuration write port
  input  wire logic        cfg_we,
  input  wire logic [0:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  h4rx_pkg::h4rx_cfg_t    cfg;
  h4rx_pkg::h4rx_result_t res;
  h4rx_pkg::h4rx_result_t out_res;

  logic       in_valid;
  logic [7:0] in_byte;
  logic       out_valid;
  logic       step;

  // Advance the held byte whenever the result register is free or draining
  assign step          = in_valid && (!out_valid || m_axis_tready);
  assign s_axis_tready = !in_valid || step;

  h4rx_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  h4rx_parser u_parser (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .rx_byte (in_byte),
    .cfg     (cfg),
    .res     (res)
  );

  // Input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_axis_tvalid && s_axis_tready) begin
      in_byte <= s_axis_tdata;
    end
  end

  // Result register: load on step, drop valid once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_res <= res;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = out_res.out_byte;
  assign m_axis_tuser  = {out_res.discardable, out_res.too_long,
                          out_res.byte_role, out_res.packet_kind};
  assign m_axis_tlast  = out_res.packet_end;

endmodule

`default_nettype wire

// ===== bench/hci_h4_rx_deframer_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// H4 receive deframer testbench
// Feeds byte streams of H4 event, ACL and ISO packets, noise and oversize
// headers into the deframer. Each accepted byte is run through a local
// packet parser, and the expected result is compared field by field with
// the master side. Both stream sides stall at random.
// ----------------------------------------------------------------------------

module hci_h4_rx_deframer_tb;

  localparam int unsigned LIMIT_CYCLES = 1000000;
  localparam int unsigned PHASE_ITEMS  = 330;
  localparam int unsigned REPORT_CAP   = 40;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;    // [7:0] rx_byte
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [7:0]  m_axis_tdata;            // [7:0] out_byte
  logic [6:0]  m_axis_tuser;            // [1:0] packet_kind, [4:2] byte_role,
                                        // [5] too_long, [6] discardable
  logic        m_axis_tlast;            // packet_end
  logic        cfg_we = 1'b0;
  logic [0:0]  cfg_index = h4rx_pkg::CFG_MAX_PAYLOAD;
  logic [15:0] cfg_data = 16'h0000;

  hci_h4_rx_deframer dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // --------------------------------------------------------------------------
  // Parser shadow: configuration and packet state as the block should hold it
  // --------------------------------------------------------------------------
  logic [15:0] max_len;
  logic        iso_on;

  logic [1:0]  pkt_kind;
  logic [7:0]  hdr [0:3];
  logic [2:0]  hdr_len;
  logic [15:0] hdr_left;        // header bytes left, then payload bytes left
  logic        in_payload;
  logic [15:0] skip_left;       // bytes of an oversize packet still to drop
  logic        adv_report;

  h4rx_pkg::h4rx_result_t parsed_q[$];    // expected results, oldest first

  int unsigned sent_items;
  int unsigned errors;
  int unsigned cycles;
  int unsigned ends_seen;
  int unsigned oversize_seen;
  int unsigned adv_bytes_seen;
  bit          src_burst;
  bit          snk_burst;

  // Back to waiting for a type byte; a pending drop count survives.
  function automatic void parser_idle();
    pkt_kind   = h4rx_pkg::KIND_NONE;
    hdr_len    = 3'd0;
    hdr_left   = 16'd0;
    in_payload = 1'b0;
    adv_report = 1'b0;
  endfunction

  // Advance the parser by one received byte and return the result it causes.
  function automatic h4rx_pkg::h4rx_result_t parse_byte(input logic [7:0] b);
    h4rx_pkg::h4rx_result_t r;
    logic [15:0]  diff;
    logic [15:0]  ext;
    logic [15:0]  plen;
    r = '0;
    r.out_byte = b;
    if (skip_left != 16'd0) begin
      // Inside the payload of an oversize packet: drop silently.
      skip_left = skip_left - 16'd1;
      r.byte_role = h4rx_pkg::ROLE_DISCARD;
    end else if (pkt_kind == h4rx_pkg::KIND_NONE) begin
      if (b == h4rx_pkg::H4_TYPE_EVT) begin
        pkt_kind = h4rx_pkg::KIND_EVT;
        hdr_len  = h4rx_pkg::HDR_LEN_EVT;
      end else if (b == h4rx_pkg::H4_TYPE_ACL) begin
        pkt_kind = h4rx_pkg::KIND_ACL;
        hdr_len  = h4rx_pkg::HDR_LEN_ACL;
      end else if (b == h4rx_pkg::H4_TYPE_ISO && iso_on) begin
        // ISO shares the 4-byte header size of ACL
        pkt_kind = h4rx_pkg::KIND_ISO;
        hdr_len  = h4rx_pkg::HDR_LEN_ACL;
      end
      if (pkt_kind != h4rx_pkg::KIND_NONE) begin
        hdr_left    = {13'd0, hdr_len};
        in_payload  = 1'b0;
        adv_report  = 1'b0;
        r.packet_kind = pkt_kind;
        r.byte_role   = h4rx_pkg::ROLE_TYPE;
      end else begin
        r.byte_role = h4rx_pkg::ROLE_UNKNOWN;
      end
    end else if (!in_payload) begin
      diff = {13'd0, hdr_len} - hdr_left;
      hdr[diff[1:0]] = b;
      hdr_left = hdr_left - 16'd1;
      r.packet_kind = pkt_kind;
      r.byte_role   = h4rx_pkg::ROLE_HEADER;
      // LE meta event: the subevent code joins the header.
      if (pkt_kind == h4rx_pkg::KIND_EVT && hdr_len == h4rx_pkg::HDR_LEN_EVT
          && hdr_left < 16'd2 && hdr[0] == h4rx_pkg::EVT_LE_META) begin
        hdr_left = hdr_left + 16'd1;
        hdr_len  = h4rx_pkg::HDR_LEN_META;
      end
      if (hdr_left == 16'd0) begin
        if (pkt_kind == h4rx_pkg::KIND_EVT) begin
          ext  = {13'd0, hdr_len} - 16'd2;
          // length below the extension saturates at zero
          plen = ({8'd0, hdr[1]} > ext) ? {8'd0, hdr[1]} - ext : 16'd0;
          if (hdr[0] == h4rx_pkg::EVT_LE_META && hdr_len == h4rx_pkg::HDR_LEN_META
              && hdr[2] == h4rx_pkg::LE_SUB_ADV_REPORT)
            adv_report = 1'b1;
        end else begin
          plen = {hdr[3], hdr[2]};
          if (pkt_kind == h4rx_pkg::KIND_ISO)
            plen[15:14] = 2'b00;
        end
        r.discardable = adv_report;
        if (plen > max_len) begin
          r.too_long = 1'b1;
          skip_left  = plen;
          parser_idle();
        end else if (plen == 16'd0) begin
          r.packet_end = 1'b1;
          parser_idle();
        end else begin
          in_payload = 1'b1;
          hdr_left   = plen;
        end
      end else begin
        r.discardable = adv_report;
      end
    end else begin
      r.packet_kind = pkt_kind;
      r.byte_role   = h4rx_pkg::ROLE_PAYLOAD;
      r.discardable = adv_report;
      hdr_left = hdr_left - 16'd1;
      if (hdr_left == 16'd0) begin
        r.packet_end = 1'b1;
        parser_idle();
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------

  // Offer one byte after a random gap, hold it until taken, then predict.
  task automatic send_item(input logic [7:0] b);
    int unsigned gap;
    if ($urandom_range(0, 47) == 0)
      src_burst = !src_burst;
    gap = src_burst ? 0 : $urandom_range(0, 18);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= b;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    parsed_q.push_back(parse_byte(b));
    sent_items++;
  endtask

  // Hold the sender off until every expected result is out, then let the
  // pipeline settle.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (parsed_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Write both registers; call only while the block is drained.
  task automatic set_config(input logic [15:0] max_payload, input logic iso_enable);
    cfg_we    <= 1'b1;
    cfg_index <= h4rx_pkg::CFG_MAX_PAYLOAD;
    cfg_data  <= max_payload;
    @(posedge clk);
    cfg_index <= h4rx_pkg::CFG_ISO_ENABLE;
    cfg_data  <= {15'd0, iso_enable};
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    max_len = max_payload;
    iso_on  = iso_enable;
  endtask

  // One well-formed packet with random kind, header fields and payload.
  task automatic send_random_packet();
    int unsigned plen;
    int unsigned i;
    logic [7:0]  code;
    logic [7:0]  sub;
    logic [7:0]  len_byte;
    case ($urandom_range(0, 9))
      0: plen = 0;
      1: plen = (max_len < 16'd200) ? max_len + $urandom_range(1, 6) : $urandom_range(0, 24);
      2: plen = (max_len < 16'd200) ? max_len : $urandom_range(0, 24);
      3: plen = $urandom_range(25, 120);
      default: plen = $urandom_range(0, 24);
    endcase
    case ($urandom_range(0, 2))
      0: begin
        code = $urandom_range(0, 1) ? h4rx_pkg::EVT_LE_META : 8'($urandom);
        send_item(h4rx_pkg::H4_TYPE_EVT);
        send_item(code);
        if (code == h4rx_pkg::EVT_LE_META) begin
          sub = $urandom_range(0, 1) ? h4rx_pkg::LE_SUB_ADV_REPORT : 8'($urandom);
          // sometimes announce less than the subevent byte itself
          len_byte = (plen == 0 && $urandom_range(0, 1)) ? 8'd0 : 8'(plen + 1);
          send_item(len_byte);
          send_item(sub);
        end else begin
          send_item(8'(plen));
        end
      end
      1: begin
        send_item(h4rx_pkg::H4_TYPE_ACL);
        send_item(8'($urandom));
        send_item(8'($urandom));
        send_item(8'(plen));
        send_item(8'(plen >> 8));
      end
      default: begin
        send_item(h4rx_pkg::H4_TYPE_ISO);
        send_item(8'($urandom));
        send_item(8'($urandom));
        send_item(8'(plen));
        // top two bits lie outside the 14-bit length
        send_item({2'($urandom), 6'(plen >> 8)});
      end
    endcase
    for (i = 0; i < plen; i++)
      send_item(8'($urandom));
  endtask

  // --------------------------------------------------------------------------
  // Directed tests
  // --------------------------------------------------------------------------

  // Bytes that name no known packet type come out one by one as unknown.
  task automatic test_unknown_types();
    send_item(8'h00);
    send_item(8'hFF);
  endtask

  // LE advertising report: header grows by the subevent, payload flagged.
  task automatic test_adv_report();
    send_item(h4rx_pkg::H4_TYPE_EVT);
    send_item(h4rx_pkg::EVT_LE_META);
    send_item(8'h02);
    send_item(h4rx_pkg::LE_SUB_ADV_REPORT);
    send_item(8'hA5);
  endtask

  // LE meta event announcing zero length: length saturates, end on subevent.
  task automatic test_meta_underflow();
    send_item(h4rx_pkg::H4_TYPE_EVT);
    send_item(h4rx_pkg::EVT_LE_META);
    send_item(8'h00);
    send_item(8'h01);
  endtask

  // ACL with all-ones handle and an empty payload ends on its last header byte.
  task automatic test_acl_empty();
    send_item(h4rx_pkg::H4_TYPE_ACL);
    send_item(8'hFF);
    send_item(8'hFF);
    send_item(8'h00);
    send_item(8'h00);
  endtask

  // With max_payload at zero any payload is oversize; the next byte is dropped.
  task automatic test_too_long();
    drain();
    set_config(16'd0, 1'b1);
    send_item(h4rx_pkg::H4_TYPE_EVT);
    send_item(8'h0E);
    send_item(8'h01);
    send_item(8'h3C);
  endtask

  // Clear iso_enable inside an ISO header: that packet still completes,
  // the next ISO type byte comes out as unknown.
  task automatic test_iso_disable_midpacket();
    send_item(h4rx_pkg::H4_TYPE_ISO);
    send_item(8'h00);
    drain();
    set_config(max_len, 1'b0);
    send_item(8'h00);
    send_item(8'h00);
    send_item(8'hC0);
    send_item(h4rx_pkg::H4_TYPE_ISO);
    drain();
  endtask

  // Random packets and noise under a series of register settings.
  task automatic test_random_traffic();
    int unsigned ph;
    int unsigned start;
    for (ph = 0; ph < 6; ph++) begin
      case (ph)
        0: set_config(h4rx_pkg::MAX_PAYLOAD_RESET, 1'b1);
        1: set_config(16'd0, 1'b1);
        2: set_config(16'hFFFF, 1'b0);
        3: set_config(16'd12, 1'b1);
        4: set_config(16'($urandom_range(0, 40)), 1'($urandom_range(0, 1)));
        default: set_config(16'hFFFF, 1'b1);
      endcase
      start = sent_items;
      while (sent_items - start < PHASE_ITEMS) begin
        if ($urandom_range(0, 7) == 0)
          repeat ($urandom_range(1, 3)) send_item(8'($urandom));
        else
          send_random_packet();
      end
      // every phase ends with the sender waiting for all results
      drain();
    end
  endtask

  // --------------------------------------------------------------------------
  // Result side: random stalls on tready, then field-by-field checks
  // --------------------------------------------------------------------------
  initial begin : result_sink
    int unsigned stall;
    forever begin
      if ($urandom_range(0, 47) == 0)
        snk_burst = !snk_burst;
      stall = snk_burst ? 0 : $urandom_range(0, 18);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
    end
  end

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      errors++;
      if (errors <= REPORT_CAP)
        $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endfunction

  always @(posedge clk) begin : result_check
    h4rx_pkg::h4rx_result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (parsed_q.size() == 0) begin
        errors++;
        if (errors <= REPORT_CAP)
          $display("%0t: unexpected result, expected none, actual byte %0h",
                   $time, m_axis_tdata);
      end else begin
        want = parsed_q.pop_front();
        check_field("out_byte",    want.out_byte,    m_axis_tdata);
        check_field("packet_kind", want.packet_kind, m_axis_tuser[1:0]);
        check_field("byte_role",   want.byte_role,   m_axis_tuser[4:2]);
        check_field("packet_end",  want.packet_end,  m_axis_tlast);
        check_field("too_long",    want.too_long,    m_axis_tuser[5]);
        check_field("discardable", want.discardable, m_axis_tuser[6]);
        if (want.packet_end)  ends_seen++;
        if (want.too_long)    oversize_seen++;
        if (want.discardable) adv_bytes_seen++;
      end
    end
  end

  // Watchdog: stop a hung run.
  always @(posedge clk) begin
    cycles++;
    if (cycles >= LIMIT_CYCLES) begin
      $display("%0t: timeout with %0d results outstanding", $time, parsed_q.size());
      $display("Regression FAIL");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------
  initial begin
    // shadow state matches the block right after reset
    max_len   = h4rx_pkg::MAX_PAYLOAD_RESET;
    iso_on    = 1'b1;
    skip_left = 16'd0;
    parser_idle();

    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_unknown_types();
    test_adv_report();
    test_meta_underflow();
    test_acl_empty();
    test_too_long();
    test_iso_disable_midpacket();
    test_random_traffic();

    drain();
    repeat (8) @(posedge clk);

    if (parsed_q.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, parsed_q.size());
    end
    $display("Covered %0d received bytes across six max_payload/iso_enable settings.",
             sent_items);
    $display("Saw %0d packet ends, %0d oversize headers, %0d advertising report bytes.",
             ends_seen, oversize_seen, adv_bytes_seen);
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/core/h4rx_pkg.sv
rtl/core/h4rx_cfg.sv
rtl/core/h4rx_parser.sv
rtl/core/hci_h4_rx_deframer.sv
bench/hci_h4_rx_deframer_tb.sv
